### sv/hlsr_pkg.sv
// Shared types, constants and helpers for the LCD scanline renderer.
// Used by hlsr_ctrl, hlsr_datapath and the top level; depends on nothing.
package hlsr_pkg;

    localparam int DEF_SCREEN_WIDTH  = 160;
    localparam int DEF_VISIBLE_LINES = 144;
    localparam int DEF_SPRITE_COUNT  = 40;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_PIXEL = 2'd3;

    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_SEARCH = 2'd2;
    localparam logic [1:0] MODE_XFER   = 2'd3;

    localparam logic [9:0] DOTS_SEARCH = 10'd80;
    localparam logic [9:0] DOTS_XFER   = 10'd172;
    localparam logic [9:0] DOTS_HBLANK = 10'd204;
    localparam logic [9:0] DOTS_LINE   = 10'd456;
    localparam logic [7:0] LAST_LINE   = 8'd153;

    localparam int VRAM_DEPTH = 8192;
    localparam int VRAM_AW    = 13;
    localparam int OAM_DEPTH  = 160;
    localparam int OAM_AW     = 8;

    localparam logic [VRAM_AW-1:0] MAP_HIGH    = 13'h1C00;
    localparam logic [VRAM_AW-1:0] MAP_LOW     = 13'h1800;
    localparam logic [VRAM_AW-1:0] SIGNED_BASE = 13'h1000;

    localparam logic [15:0] OAM_FIRST = 16'hFE00;
    localparam logic [15:0] OAM_LAST  = 16'hFE9F;
    localparam logic [15:0] REG_LCDC  = 16'hFF40;
    localparam logic [15:0] REG_STAT  = 16'hFF41;
    localparam logic [15:0] REG_SCY   = 16'hFF42;
    localparam logic [15:0] REG_SCX   = 16'hFF43;
    localparam logic [15:0] REG_LY    = 16'hFF44;
    localparam logic [15:0] REG_LYC   = 16'hFF45;
    localparam logic [15:0] REG_BGP   = 16'hFF47;
    localparam logic [15:0] REG_OBP0  = 16'hFF48;
    localparam logic [15:0] REG_OBP1  = 16'hFF49;
    localparam logic [15:0] REG_WY    = 16'hFF4A;
    localparam logic [15:0] REG_WX    = 16'hFF4B;

    localparam logic [7:0] LCDC_RESET = 8'h91;
    localparam logic [7:0] STAT_RESET = 8'h85;
    localparam logic [7:0] BGP_RESET  = 8'hFC;
    localparam logic [7:0] OBP_RESET  = 8'hFF;

    typedef struct packed {
        logic clear;
        logic capture;
        logic exec;
        logic bg_map;
        logic bg_lo;
        logic bg_hi;
        logic bg_wr;
        logic sp_y;
        logic sp_x;
        logic sp_t;
        logic sp_a;
        logic sp_chk;
        logic sp_lo;
        logic sp_hi;
        logic sp_pix;
        logic sp_next;
        logic load_out;
    } hlsr_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic render_go;
        logic sprites_on;
        logic px_last;
        logic sp_hit;
        logic sp_last;
        logic k_last;
    } hlsr_status_t;

    function automatic logic [31:0] shade_argb(input logic [1:0] shade);
        logic [31:0] c;
        case (shade)
            2'd0:    c = 32'hFFE0F8D0;
            2'd1:    c = 32'hFF88C070;
            2'd2:    c = 32'hFF346856;
            default: c = 32'hFF081820;
        endcase
        return c;
    endfunction

endpackage

### sv/hlsr_ctrl.sv
// Sequencer for the LCD scanline renderer: clear pass, item execution,
// line render steps and the output handshake. Uses hlsr_pkg.
module hlsr_ctrl
    import hlsr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  logic         out_stall,
    input  hlsr_status_t sts,
    output hlsr_cmd_t    cmd
);

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_EXEC   = 4'd2;
    localparam logic [3:0] ST_BG_MAP = 4'd3;
    localparam logic [3:0] ST_BG_LO  = 4'd4;
    localparam logic [3:0] ST_BG_HI  = 4'd5;
    localparam logic [3:0] ST_BG_WR  = 4'd6;
    localparam logic [3:0] ST_SP_Y   = 4'd7;
    localparam logic [3:0] ST_SP_X   = 4'd8;
    localparam logic [3:0] ST_SP_T   = 4'd9;
    localparam logic [3:0] ST_SP_A   = 4'd10;
    localparam logic [3:0] ST_SP_CHK = 4'd11;
    localparam logic [3:0] ST_SP_LO  = 4'd12;
    localparam logic [3:0] ST_SP_HI  = 4'd13;
    localparam logic [3:0] ST_SP_PIX = 4'd14;
    localparam logic [3:0] ST_FIN    = 4'd15;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = sts.render_go ? ST_BG_MAP : ST_FIN;
            end
            ST_BG_MAP:
            begin
                cmd.bg_map = 1'b1;
                state_next = ST_BG_LO;
            end
            ST_BG_LO:
            begin
                cmd.bg_lo  = 1'b1;
                state_next = ST_BG_HI;
            end
            ST_BG_HI:
            begin
                cmd.bg_hi  = 1'b1;
                state_next = ST_BG_WR;
            end
            ST_BG_WR:
            begin
                cmd.bg_wr = 1'b1;
                if (!sts.px_last)
                    state_next = ST_BG_MAP;
                else if (sts.sprites_on)
                    state_next = ST_SP_Y;
                else
                    state_next = ST_FIN;
            end
            ST_SP_Y:
            begin
                cmd.sp_y   = 1'b1;
                state_next = ST_SP_X;
            end
            ST_SP_X:
            begin
                cmd.sp_x   = 1'b1;
                state_next = ST_SP_T;
            end
            ST_SP_T:
            begin
                cmd.sp_t   = 1'b1;
                state_next = ST_SP_A;
            end
            ST_SP_A:
            begin
                cmd.sp_a   = 1'b1;
                state_next = ST_SP_CHK;
            end
            ST_SP_CHK:
            begin
                cmd.sp_chk = 1'b1;
                if (sts.sp_hit)
                    state_next = ST_SP_LO;
                else
                begin
                    cmd.sp_next = 1'b1;
                    state_next  = sts.sp_last ? ST_FIN : ST_SP_Y;
                end
            end
            ST_SP_LO:
            begin
                cmd.sp_lo  = 1'b1;
                state_next = ST_SP_HI;
            end
            ST_SP_HI:
            begin
                cmd.sp_hi  = 1'b1;
                state_next = ST_SP_PIX;
            end
            ST_SP_PIX:
            begin
                cmd.sp_pix = 1'b1;
                if (sts.k_last)
                begin
                    cmd.sp_next = 1'b1;
                    state_next  = sts.sp_last ? ST_FIN : ST_SP_Y;
                end
            end
            ST_FIN:
            begin
                // hold the result until the output register frees up
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (cmd.load_out)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### sv/hlsr_datapath.sv
// Datapath of the LCD scanline renderer: LCD registers, video RAM, sprite
// table, frame store, dot/line timing, line render and result registers.
// Uses hlsr_pkg; driven by hlsr_ctrl commands.
module hlsr_datapath
    import hlsr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int VISIBLE_LINES = DEF_VISIBLE_LINES,
    parameter int SPRITE_COUNT  = DEF_SPRITE_COUNT
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  hlsr_cmd_t    cmd,
    output hlsr_status_t sts,
    input  logic [1:0]   op,
    input  logic [6:0]   ticks,
    input  logic [15:0]  bus_address,
    input  logic [7:0]   write_data,
    output logic [7:0]   read_data,
    output logic [1:0]   pixel_shade,
    output logic [31:0]  pixel_argb,
    output logic         vblank_irq,
    output logic         stat_irq,
    output logic [1:0]   lcd_mode
);

    localparam int FRAME_SIZE = SCREEN_WIDTH * VISIBLE_LINES;
    localparam int FS_AW      = $clog2(FRAME_SIZE);
    localparam int PX_W       = $clog2(SCREEN_WIDTH);
    localparam int SP_W       = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
    localparam int CLR_N      = (FRAME_SIZE > VRAM_DEPTH) ? FRAME_SIZE : VRAM_DEPTH;
    localparam int CLR_W      = $clog2(CLR_N + 1);

    // memories
    logic [7:0] vram_mem [VRAM_DEPTH];
    logic [7:0] oam_mem  [OAM_DEPTH];
    logic [1:0] fs_mem   [FRAME_SIZE];

    logic [VRAM_AW-1:0] vram_addr;
    logic               vram_we;
    logic [7:0]         vram_wd;
    logic [7:0]         vram_q;
    logic [OAM_AW-1:0]  oam_addr;
    logic               oam_we;
    logic [7:0]         oam_wd;
    logic [7:0]         oam_q;
    logic [FS_AW-1:0]   fs_wa;
    logic [FS_AW-1:0]   fs_ra;
    logic               fs_we;
    logic [1:0]         fs_wd;
    logic [1:0]         fs_q;

    // LCD registers
    logic [7:0] lcdc_reg, stat_reg, scy_reg, scx_reg, ly_reg, lyc_reg;
    logic [7:0] bgp_reg, obp0_reg, obp1_reg, wy_reg, wx_reg;
    logic [9:0] dot_reg;
    logic       vb_reg, st_reg;
    logic [CLR_W-1:0] clr_cnt_reg;

    // item and render work registers
    logic [1:0]         op_reg;
    logic [6:0]         ticks_reg;
    logic [15:0]        addr_reg;
    logic [7:0]         wdata_reg;
    logic [FS_AW-1:0]   row_base_reg;
    logic [PX_W-1:0]    px_reg;
    logic [SP_W-1:0]    sp_idx_reg;
    logic [2:0]         k_reg;
    logic [VRAM_AW-1:0] tile_addr_reg;
    logic [7:0]         lo_reg, hi_reg;
    logic [7:0]         y_reg, x_reg, tile_reg, attr_reg;

    // tick evaluation
    logic [9:0] t_sum, t_dot;
    logic [7:0] t_line, t_stat;
    logic       t_vb, t_st, t_render;

    logic in_vram, in_oam, fs_in;
    logic was_on;

    logic [7:0]         yp, xp, bg_tile;
    logic [VRAM_AW-1:0] map_addr, bg_tbase, bg_lo_addr;
    logic [1:0]         bg_col, bg_shade;
    logic [9:0]         sp_dy, sp_xx;
    logic [2:0]         sp_line, sp_bit;
    logic [VRAM_AW-1:0] sp_lo_addr;
    logic [1:0]         sp_col, sp_shade;
    logic [7:0]         sp_pal;
    logic [7:0]         rd_val;

    assign in_vram = (addr_reg[15:13] == 3'b100);
    assign in_oam  = (addr_reg >= OAM_FIRST) && (addr_reg <= OAM_LAST);
    assign fs_in   = (addr_reg < 16'(FRAME_SIZE));
    assign was_on  = lcdc_reg[7];

    always_comb
    begin
        t_sum    = dot_reg + 10'(ticks_reg);
        t_dot    = dot_reg;
        t_line   = ly_reg;
        t_stat   = stat_reg;
        t_vb     = 1'b0;
        t_st     = 1'b0;
        t_render = 1'b0;
        if (lcdc_reg[7])
        begin
            t_dot = t_sum;
            case (stat_reg[1:0])
                MODE_SEARCH:
                begin
                    if (t_sum >= DOTS_SEARCH)
                    begin
                        t_dot         = t_sum - DOTS_SEARCH;
                        t_stat[1:0]   = MODE_XFER;
                    end
                end
                MODE_XFER:
                begin
                    if (t_sum >= DOTS_XFER)
                    begin
                        t_dot       = t_sum - DOTS_XFER;
                        t_stat[1:0] = MODE_HBLANK;
                        t_st        = stat_reg[3];
                        t_render    = (ly_reg < 8'(VISIBLE_LINES));
                    end
                end
                MODE_HBLANK:
                begin
                    if (t_sum >= DOTS_HBLANK)
                    begin
                        t_dot     = t_sum - DOTS_HBLANK;
                        t_line    = ly_reg + 8'd1;
                        t_stat[2] = (t_line == lyc_reg);
                        if (t_stat[2] && t_stat[6])
                            t_st = 1'b1;
                        if (t_line == 8'(VISIBLE_LINES))
                        begin
                            t_stat[1:0] = MODE_VBLANK;
                            t_vb        = 1'b1;
                            if (t_stat[4])
                                t_st = 1'b1;
                        end
                        else
                        begin
                            t_stat[1:0] = MODE_SEARCH;
                            if (t_stat[5])
                                t_st = 1'b1;
                        end
                    end
                end
                default:
                begin
                    if (t_sum >= DOTS_LINE)
                    begin
                        t_dot     = t_sum - DOTS_LINE;
                        t_line    = ly_reg + 8'd1;
                        t_stat[2] = (t_line == lyc_reg);
                        if (t_stat[2] && t_stat[6])
                            t_st = 1'b1;
                        // wrap to the top of the frame
                        if (t_line > LAST_LINE)
                        begin
                            t_line      = 8'd0;
                            t_stat[1:0] = MODE_SEARCH;
                            t_stat[2]   = (lyc_reg == 8'd0);
                            if (t_stat[2] && t_stat[6])
                                t_st = 1'b1;
                            if (t_stat[5])
                                t_st = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    // background pixel addressing
    always_comb
    begin
        yp         = ly_reg + scy_reg;
        xp         = 8'(px_reg) + scx_reg;
        map_addr   = (lcdc_reg[3] ? MAP_HIGH : MAP_LOW) + 13'({yp[7:3], xp[7:3]});
        bg_tile    = vram_q;
        bg_tbase   = (lcdc_reg[4] || bg_tile[7]) ? 13'({bg_tile, 4'b0000})
                                                 : SIGNED_BASE + 13'({bg_tile, 4'b0000});
        bg_lo_addr = bg_tbase + 13'({yp[2:0], 1'b0});
        bg_col     = {vram_q[~xp[2:0]], lo_reg[~xp[2:0]]};
        bg_shade   = lcdc_reg[0] ? bgp_reg[{bg_col, 1'b0} +: 2] : 2'd0;
    end

    // sprite row test and pixel select
    always_comb
    begin
        sp_dy      = 10'(ly_reg) + 10'd16 - 10'(y_reg);
        sp_line    = oam_q[6] ? ~sp_dy[2:0] : sp_dy[2:0];
        sp_lo_addr = 13'({tile_reg, sp_line, 1'b0});
        sp_xx      = 10'(x_reg) + 10'(k_reg) - 10'd8;
        sp_bit     = attr_reg[5] ? k_reg : ~k_reg;
        sp_col     = {hi_reg[sp_bit], lo_reg[sp_bit]};
        sp_pal     = attr_reg[4] ? obp1_reg : obp0_reg;
        sp_shade   = sp_pal[{sp_col, 1'b0} +: 2];
    end

    always_comb
    begin
        sts.clear_done = (clr_cnt_reg == CLR_W'(CLR_N - 1));
        sts.render_go  = (op_reg == OP_TICK) && t_render;
        sts.sprites_on = lcdc_reg[1];
        sts.px_last    = (px_reg == PX_W'(SCREEN_WIDTH - 1));
        sts.sp_hit     = (sp_dy[9:3] == 7'd0);
        sts.sp_last    = (sp_idx_reg == SP_W'(SPRITE_COUNT - 1));
        sts.k_last     = (k_reg == 3'd7);
    end

    // memory port selection; idle ports read the item address (OAM and frame store only when it is in their range)
    always_comb
    begin
        vram_addr = addr_reg[VRAM_AW-1:0];
        vram_we   = 1'b0;
        vram_wd   = wdata_reg;
        oam_addr  = in_oam ? addr_reg[OAM_AW-1:0] : '0;
        oam_we    = 1'b0;
        oam_wd    = wdata_reg;
        fs_wa     = row_base_reg + FS_AW'(px_reg);
        fs_we     = 1'b0;
        fs_wd     = bg_shade;
        fs_ra     = fs_in ? FS_AW'(addr_reg) : '0;
        if (cmd.clear)
        begin
            vram_addr = VRAM_AW'(clr_cnt_reg);
            vram_we   = (clr_cnt_reg < CLR_W'(VRAM_DEPTH));
            vram_wd   = 8'd0;
            oam_addr  = OAM_AW'(clr_cnt_reg);
            oam_we    = (clr_cnt_reg < CLR_W'(OAM_DEPTH));
            oam_wd    = 8'd0;
            fs_wa     = FS_AW'(clr_cnt_reg);
            fs_we     = (clr_cnt_reg < CLR_W'(FRAME_SIZE));
            fs_wd     = 2'd0;
        end
        else if (cmd.exec)
        begin
            vram_we = (op_reg == OP_WRITE) && in_vram;
            oam_we  = (op_reg == OP_WRITE) && in_oam;
        end
        else if (cmd.bg_map)
            vram_addr = map_addr;
        else if (cmd.bg_lo)
            vram_addr = bg_lo_addr;
        else if (cmd.bg_hi || cmd.sp_lo)
            vram_addr = tile_addr_reg + 13'd1;
        else if (cmd.bg_wr)
            fs_we = 1'b1;
        else if (cmd.sp_y)
            oam_addr = OAM_AW'({sp_idx_reg, 2'd0});
        else if (cmd.sp_x)
            oam_addr = OAM_AW'({sp_idx_reg, 2'd1});
        else if (cmd.sp_t)
            oam_addr = OAM_AW'({sp_idx_reg, 2'd2});
        else if (cmd.sp_a)
            oam_addr = OAM_AW'({sp_idx_reg, 2'd3});
        else if (cmd.sp_chk)
            vram_addr = sp_lo_addr;
        else if (cmd.sp_pix)
        begin
            fs_wa = row_base_reg + FS_AW'(sp_xx[7:0]);
            fs_wd = sp_shade;
            // drop transparent and off-screen sprite pixels
            fs_we = (sp_col != 2'd0) && (sp_xx < 10'(SCREEN_WIDTH));
        end
    end

    always_ff @(posedge clk)
    begin
        if (vram_we)
            vram_mem[vram_addr] <= vram_wd;
        vram_q <= vram_mem[vram_addr];
    end

    always_ff @(posedge clk)
    begin
        if (oam_we)
            oam_mem[oam_addr] <= oam_wd;
        oam_q <= oam_mem[oam_addr];
    end

    always_ff @(posedge clk)
    begin
        if (fs_we)
            fs_mem[fs_wa] <= fs_wd;
        fs_q <= fs_mem[fs_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcdc_reg    <= LCDC_RESET;
            stat_reg    <= STAT_RESET;
            scy_reg     <= 8'd0;
            scx_reg     <= 8'd0;
            ly_reg      <= 8'd0;
            lyc_reg     <= 8'd0;
            bgp_reg     <= BGP_RESET;
            obp0_reg    <= OBP_RESET;
            obp1_reg    <= OBP_RESET;
            wy_reg      <= 8'd0;
            wx_reg      <= 8'd0;
            dot_reg     <= 10'd0;
            vb_reg      <= 1'b0;
            st_reg      <= 1'b0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.clear && !sts.clear_done)
                clr_cnt_reg <= clr_cnt_reg + CLR_W'(1);
            if (cmd.exec)
            begin
                if (op_reg == OP_TICK)
                begin
                    dot_reg  <= t_dot;
                    ly_reg   <= t_line;
                    stat_reg <= t_stat;
                    vb_reg   <= t_vb;
                    st_reg   <= t_st;
                end
                else
                begin
                    vb_reg <= 1'b0;
                    st_reg <= 1'b0;
                    if (op_reg == OP_WRITE)
                    begin
                        unique case (addr_reg)
                            REG_LCDC:
                            begin
                                lcdc_reg <= wdata_reg;
                                if (was_on && !wdata_reg[7])
                                begin
                                    ly_reg        <= 8'd0;
                                    dot_reg       <= 10'd0;
                                    stat_reg[1:0] <= MODE_HBLANK;
                                end
                            end
                            REG_STAT: stat_reg <= (stat_reg & 8'h87) | (wdata_reg & 8'h78);
                            REG_SCY:  scy_reg  <= wdata_reg;
                            REG_SCX:  scx_reg  <= wdata_reg;
                            REG_LYC:  lyc_reg  <= wdata_reg;
                            REG_BGP:  bgp_reg  <= wdata_reg;
                            REG_OBP0: obp0_reg <= wdata_reg;
                            REG_OBP1: obp1_reg <= wdata_reg;
                            REG_WY:   wy_reg   <= wdata_reg;
                            REG_WX:   wx_reg   <= wdata_reg;
                            default:  ;
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= op;
            ticks_reg <= ticks;
            addr_reg  <= bus_address;
            wdata_reg <= write_data;
        end
        if (cmd.exec)
        begin
            row_base_reg <= FS_AW'(ly_reg * SCREEN_WIDTH);
            px_reg       <= '0;
            sp_idx_reg   <= '0;
        end
        if (cmd.bg_lo)
            tile_addr_reg <= bg_lo_addr;
        if (cmd.bg_hi || cmd.sp_lo)
            lo_reg <= vram_q;
        if (cmd.bg_wr)
            px_reg <= px_reg + PX_W'(1);
        if (cmd.sp_x)
            y_reg <= oam_q;
        if (cmd.sp_t)
            x_reg <= oam_q;
        if (cmd.sp_a)
            tile_reg <= oam_q;
        if (cmd.sp_chk)
        begin
            attr_reg      <= oam_q;
            tile_addr_reg <= sp_lo_addr;
        end
        if (cmd.sp_hi)
        begin
            hi_reg <= vram_q;
            k_reg  <= 3'd0;
        end
        if (cmd.sp_pix)
            k_reg <= k_reg + 3'd1;
        if (cmd.sp_next)
            sp_idx_reg <= sp_idx_reg + SP_W'(1);
    end

    always_comb
    begin
        rd_val = 8'hFF;
        if (in_vram)
            rd_val = vram_q;
        else if (in_oam)
            rd_val = oam_q;
        else
        begin
            unique case (addr_reg)
                REG_LCDC: rd_val = lcdc_reg;
                REG_STAT: rd_val = stat_reg;
                REG_SCY:  rd_val = scy_reg;
                REG_SCX:  rd_val = scx_reg;
                REG_LY:   rd_val = ly_reg;
                REG_LYC:  rd_val = lyc_reg;
                REG_BGP:  rd_val = bgp_reg;
                REG_OBP0: rd_val = obp0_reg;
                REG_OBP1: rd_val = obp1_reg;
                REG_WY:   rd_val = wy_reg;
                REG_WX:   rd_val = wx_reg;
                default:  rd_val = 8'hFF;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            read_data   <= (op_reg == OP_READ) ? rd_val : 8'd0;
            pixel_shade <= (op_reg == OP_PIXEL && fs_in) ? fs_q : 2'd0;
            pixel_argb  <= (op_reg == OP_PIXEL) ? shade_argb(fs_in ? fs_q : 2'd0) : 32'd0;
            vblank_irq  <= vb_reg;
            stat_irq    <= st_reg;
            lcd_mode    <= stat_reg[1:0];
        end
    end

endmodule

### sv/handheld_lcd_scanline_renderer.sv
// Each item is captured on accept, executed, then loaded into the result
// registers once the output is free. A tick that ends a visible line's
// transfer also renders it: a background fetch for every pixel, then, with
// sprites on, a test of every sprite and a fetch and draw of those on the line.
// One item in work at a time. After reset a clearing pass zeroes the memories,
// stall held.
module handheld_lcd_scanline_renderer
    import hlsr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int VISIBLE_LINES = DEF_VISIBLE_LINES,
    parameter int SPRITE_COUNT  = DEF_SPRITE_COUNT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [6:0]  ticks,
    input  logic [15:0] bus_address,
    input  logic [7:0]  write_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic [1:0]  pixel_shade,
    output logic [31:0] pixel_argb,
    output logic        vblank_irq,
    output logic        stat_irq,
    output logic [1:0]  lcd_mode
);

    hlsr_cmd_t    cmd;
    hlsr_status_t sts;

    hlsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    hlsr_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .VISIBLE_LINES (VISIBLE_LINES),
        .SPRITE_COUNT  (SPRITE_COUNT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .op          (op),
        .ticks       (ticks),
        .bus_address (bus_address),
        .write_data  (write_data),
        .read_data   (read_data),
        .pixel_shade (pixel_shade),
        .pixel_argb  (pixel_argb),
        .vblank_irq  (vblank_irq),
        .stat_irq    (stat_irq),
        .lcd_mode    (lcd_mode)
    );

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(out_valid && out_stall))
        else $error("result loaded over an untaken item");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> cmd.exec)
        else $error("accepted item not executed next cycle");

    a_vblank_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && vblank_irq) |-> (lcd_mode == MODE_VBLANK))
        else $error("vblank request without vblank mode");

endmodule

### sim/tb.sv
// Testbench for handheld_lcd_scanline_renderer: drives tick, bus and frame read items
// and checks every result against a behavioral LCD controller model kept here.
// Depends on hlsr_pkg and the RTL top level.
module tb;
    import hlsr_pkg::*;

    localparam int WIDTH   = DEF_SCREEN_WIDTH;
    localparam int LINES   = DEF_VISIBLE_LINES;
    localparam int NSPRITE = DEF_SPRITE_COUNT;
    localparam int FRAME   = WIDTH * LINES;
    localparam int WATCHDOG_LIMIT = 100000;

    typedef struct packed {
        logic [7:0]  rd;
        logic [1:0]  shade;
        logic [31:0] argb;
        logic        vbl;
        logic        stat;
        logic [1:0]  mode;
    } lcd_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  op;
    logic [6:0]  ticks;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  read_data;
    logic [1:0]  pixel_shade;
    logic [31:0] pixel_argb;
    logic        vblank_irq;
    logic        stat_irq;
    logic [1:0]  lcd_mode;

    // model state
    logic [7:0] m_vram [0:8191];
    logic [7:0] m_oam [0:159];
    logic [1:0] m_frame [0:FRAME-1];
    logic [7:0] m_lcdc, m_stat, m_scy, m_scx, m_ly, m_lyc, m_bgp, m_obp0, m_obp1, m_wy, m_wx;
    logic [9:0] m_dots;
    logic       m_irq_stat, m_irq_vbl;

    lcd_result_t pending_results[$];
    int  errors;
    int  idle_cycles;
    bit  sender_idle_on;
    bit  receiver_idle_on;

    handheld_lcd_scanline_renderer dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .ticks(ticks), .bus_address(bus_address), .write_data(write_data),
        .out_valid(out_valid), .out_stall(out_stall), .read_data(read_data),
        .pixel_shade(pixel_shade), .pixel_argb(pixel_argb), .vblank_irq(vblank_irq),
        .stat_irq(stat_irq), .lcd_mode(lcd_mode)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] colour_of(input logic [1:0] s);
        case (s)
            2'd0:    return 32'hFFE0F8D0;
            2'd1:    return 32'hFF88C070;
            2'd2:    return 32'hFF346856;
            default: return 32'hFF081820;
        endcase
    endfunction

    task automatic model_reset();
        for (int i = 0; i < 8192; i++) m_vram[i] = 8'h00;
        for (int i = 0; i < 160; i++) m_oam[i] = 8'h00;
        for (int i = 0; i < FRAME; i++) m_frame[i] = 2'd0;
        m_lcdc = LCDC_RESET; m_stat = STAT_RESET; m_scy = 0; m_scx = 0; m_ly = 0; m_lyc = 0;
        m_bgp = BGP_RESET; m_obp0 = OBP_RESET; m_obp1 = OBP_RESET; m_wy = 0; m_wx = 0;
        m_dots = 0;
    endtask

    function automatic logic [1:0] tile_pixel(input int addr, input int bitpos);
        logic [7:0] lo, hi;
        lo = m_vram[addr & 13'h1FFF];
        hi = m_vram[(addr + 1) & 13'h1FFF];
        return {hi[bitpos], lo[bitpos]};
    endfunction

    function automatic void set_mode(input logic [1:0] m);
        m_stat[1:0] = m;
    endfunction

    function automatic void compare_line();
        if (m_ly == m_lyc)
        begin
            m_stat[2] = 1'b1;
            if (m_stat[6]) m_irq_stat = 1'b1;
        end
        else
            m_stat[2] = 1'b0;
    endfunction

    function automatic void draw_line();
        int row, base, tile, addr, sy, sx, lrow, x, bitpos;
        logic [7:0] yp, xp, pal, attr;
        logic [1:0] col;
        row = m_ly;
        if (row >= LINES) return;
        base = row * WIDTH;
        for (int px = 0; px < WIDTH; px++)
        begin
            m_frame[base + px] = 2'd0;
            if (m_lcdc[0])
            begin
                yp = 8'(row + m_scy);
                xp = 8'(px + m_scx);
                tile = m_vram[((m_lcdc[3] ? 32'h1C00 : 32'h1800) + (yp >> 3) * 32 + (xp >> 3))
                              & 13'h1FFF];
                addr = (m_lcdc[4] || tile >= 128) ? tile * 16 : 32'h1000 + tile * 16;
                col = tile_pixel(addr + yp[2:0] * 2, 7 - xp[2:0]);
                m_frame[base + px] = m_bgp[2 * col +: 2];
            end
        end
        if (!m_lcdc[1]) return;
        for (int i = 0; i < NSPRITE; i++)
        begin
            sy = int'(m_oam[i*4]) - 16;
            sx = int'(m_oam[i*4+1]) - 8;
            tile = m_oam[i*4+2];
            attr = m_oam[i*4+3];
            pal = attr[4] ? m_obp1 : m_obp0;
            if (row < sy || row >= sy + 8) continue;
            lrow = row - sy;
            if (attr[6]) lrow = 7 - lrow;
            addr = tile * 16 + lrow * 2;
            for (int k = 0; k < 8; k++)
            begin
                x = sx + k;
                bitpos = attr[5] ? k : 7 - k;
                if (x < 0 || x >= WIDTH) continue;
                col = tile_pixel(addr, bitpos);
                if (col != 0) m_frame[base + x] = pal[2 * col +: 2];
            end
        end
    endfunction

    function automatic void advance_dots(input int n);
        if (!m_lcdc[7]) return;
        m_dots = 10'(m_dots + n);
        case (m_stat[1:0])
            MODE_SEARCH:
                if (m_dots >= DOTS_SEARCH)
                begin
                    m_dots -= DOTS_SEARCH;
                    set_mode(MODE_XFER);
                end
            MODE_XFER:
                if (m_dots >= DOTS_XFER)
                begin
                    m_dots -= DOTS_XFER;
                    set_mode(MODE_HBLANK);
                    if (m_stat[3]) m_irq_stat = 1'b1;
                    draw_line();
                end
            MODE_HBLANK:
                if (m_dots >= DOTS_HBLANK)
                begin
                    m_dots -= DOTS_HBLANK;
                    m_ly++;
                    compare_line();
                    if (m_ly == LINES)
                    begin
                        set_mode(MODE_VBLANK);
                        m_irq_vbl = 1'b1;
                        if (m_stat[4]) m_irq_stat = 1'b1;
                    end
                    else
                    begin
                        set_mode(MODE_SEARCH);
                        if (m_stat[5]) m_irq_stat = 1'b1;
                    end
                end
            default:
                if (m_dots >= DOTS_LINE)
                begin
                    m_dots -= DOTS_LINE;
                    m_ly++;
                    compare_line();
                    if (m_ly > LAST_LINE)
                    begin
                        m_ly = 0;
                        set_mode(MODE_SEARCH);
                        compare_line();
                        if (m_stat[5]) m_irq_stat = 1'b1;
                    end
                end
        endcase
    endfunction

    function automatic logic [7:0] bus_peek(input logic [15:0] a);
        if (a >= 16'h8000 && a <= 16'h9FFF) return m_vram[a - 16'h8000];
        if (a >= OAM_FIRST && a <= OAM_LAST) return m_oam[a - OAM_FIRST];
        case (a)
            REG_LCDC: return m_lcdc;
            REG_STAT: return m_stat;
            REG_SCY:  return m_scy;
            REG_SCX:  return m_scx;
            REG_LY:   return m_ly;
            REG_LYC:  return m_lyc;
            REG_BGP:  return m_bgp;
            REG_OBP0: return m_obp0;
            REG_OBP1: return m_obp1;
            REG_WY:   return m_wy;
            REG_WX:   return m_wx;
            default:  return 8'hFF;
        endcase
    endfunction

    function automatic void bus_poke(input logic [15:0] a, input logic [7:0] d);
        if (a >= 16'h8000 && a <= 16'h9FFF) m_vram[a - 16'h8000] = d;
        else if (a >= OAM_FIRST && a <= OAM_LAST) m_oam[a - OAM_FIRST] = d;
        else
            case (a)
                REG_LCDC:
                begin
                    if (m_lcdc[7] && !d[7])
                    begin
                        m_ly = 0;
                        m_dots = 0;
                        set_mode(MODE_HBLANK);
                    end
                    m_lcdc = d;
                end
                REG_STAT: m_stat = (m_stat & 8'h87) | (d & 8'h78);
                REG_SCY:  m_scy = d;
                REG_SCX:  m_scx = d;
                REG_LYC:  m_lyc = d;
                REG_BGP:  m_bgp = d;
                REG_OBP0: m_obp0 = d;
                REG_OBP1: m_obp1 = d;
                REG_WY:   m_wy = d;
                REG_WX:   m_wx = d;
                default:  ;
            endcase
    endfunction

    function automatic lcd_result_t predict_item(input logic [1:0] o, input logic [6:0] t,
                                                 input logic [15:0] a, input logic [7:0] d);
        lcd_result_t r;
        r = '0;
        m_irq_stat = 1'b0;
        m_irq_vbl = 1'b0;
        case (o)
            OP_TICK:  advance_dots(t);
            OP_READ:  r.rd = bus_peek(a);
            OP_WRITE: bus_poke(a, d);
            default:
            begin
                r.shade = (a < FRAME) ? m_frame[a] : 2'd0;
                r.argb = colour_of(r.shade);
            end
        endcase
        r.vbl = m_irq_vbl;
        r.stat = m_irq_stat;
        r.mode = m_stat[1:0];
        return r;
    endfunction

    // Send one item; optional idle burst before it.
    task automatic send_item(input logic [1:0] o, input logic [6:0] t,
                             input logic [15:0] a, input logic [7:0] d);
        if (sender_idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        ticks <= t;
        bus_address <= a;
        write_data <= d;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pending_results.push_back(predict_item(o, t, a, d));
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (1300) @(negedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        lcd_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual rd=%h", $time, read_data);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (read_data !== want.rd)
                begin
                    $display("%0t read_data expected %h actual %h", $time, want.rd, read_data);
                    errors++;
                end
                if (pixel_shade !== want.shade)
                begin
                    $display("%0t pixel_shade expected %h actual %h", $time, want.shade,
                             pixel_shade);
                    errors++;
                end
                if (pixel_argb !== want.argb)
                begin
                    $display("%0t pixel_argb expected %h actual %h", $time, want.argb,
                             pixel_argb);
                    errors++;
                end
                if (vblank_irq !== want.vbl)
                begin
                    $display("%0t vblank_irq expected %b actual %b", $time, want.vbl,
                             vblank_irq);
                    errors++;
                end
                if (stat_irq !== want.stat)
                begin
                    $display("%0t stat_irq expected %b actual %b", $time, want.stat, stat_irq);
                    errors++;
                end
                if (lcd_mode !== want.mode)
                begin
                    $display("%0t lcd_mode expected %h actual %h", $time, want.mode, lcd_mode);
                    errors++;
                end
            end
        end
    end

    // receiver stall bursts
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (receiver_idle_on && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog on accept-free cycles; covers the clearing pass and a full render
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic test_registers();
        logic [15:0] regs [0:11];
        regs = '{REG_LCDC, REG_STAT, REG_SCY, REG_SCX, REG_LY, REG_LYC, 16'hFF46,
                 REG_BGP, REG_OBP0, REG_OBP1, REG_WY, REG_WX};
        for (int i = 0; i < 12; i++) send_item(OP_READ, 7'd0, regs[i], 8'h00);
        send_item(OP_WRITE, 7'd0, REG_STAT, 8'hFF);
        send_item(OP_WRITE, 7'd0, REG_LY, 8'h55);
        send_item(OP_WRITE, 7'd0, REG_SCY, 8'hFF);
        send_item(OP_WRITE, 7'd0, REG_WX, 8'hA5);
        send_item(OP_READ, 7'd0, REG_STAT, 8'h00);
        send_item(OP_READ, 7'd0, 16'hFEA0, 8'h00);
        send_item(OP_READ, 7'd0, 16'hFFFF, 8'h00);
        send_item(OP_WRITE, 7'd0, 16'h9FFF, 8'hFF);
        send_item(OP_READ, 7'd0, 16'h9FFF, 8'h00);
        send_item(OP_PIXEL, 7'd0, 16'hFFFF, 8'h00);
        send_item(OP_PIXEL, 7'd0, 16'(FRAME - 1), 8'h00);
    endtask

    task automatic test_display_off();
        send_item(OP_WRITE, 7'd0, REG_LCDC, 8'h11);
        send_item(OP_TICK, 7'd64, 16'h0000, 8'h00);
        send_item(OP_WRITE, 7'd0, REG_LCDC, 8'h93);
        send_item(OP_TICK, 7'd0, 16'h0000, 8'h00);
    endtask

    // sprites, tiles and registers written at random, mixed with ticks, reads and pixel reads
    task automatic test_frames(input int n_items, input bit broad);
        int sel;
        logic [15:0] a;
        for (int i = 0; i < n_items; i++)
        begin
            if (broad && i == n_items / 2)
                drain_results();
            sel = $urandom_range(0, 99);
            if (sel < 55)
                send_item(OP_TICK, 7'($urandom_range(0, 64)), 16'($urandom), 8'($urandom));
            else if (sel < 70)
            begin
                case ($urandom_range(0, 3))
                    0: a = 16'(16'h8000 + $urandom_range(0, 16'h1FFF));
                    1: a = 16'(16'h9800 + $urandom_range(0, 16'h07FF));
                    2: a = 16'(OAM_FIRST + $urandom_range(0, 159));
                    default: a = 16'(16'hFF40 + $urandom_range(0, 11));
                endcase
                if (a == REG_LCDC && $urandom_range(0, 3) != 0)
                    send_item(OP_WRITE, 7'd0, a, {$urandom_range(0, 7) != 0, 7'($urandom)});
                else
                    send_item(OP_WRITE, 7'd0, a, 8'($urandom));
            end
            else if (sel < 80)
                send_item(OP_READ, 7'($urandom), $urandom_range(0, 3) == 0 ? 16'($urandom)
                          : 16'(16'hFF40 + $urandom_range(0, 15)), 8'($urandom));
            else
                send_item(OP_PIXEL, 7'($urandom), $urandom_range(0, 7) == 0 ? 16'($urandom)
                          : 16'($urandom_range(0, FRAME - 1)), 8'($urandom));
        end
    endtask

    task automatic test_sprites();
        for (int i = 0; i < 160; i++)
            send_item(OP_WRITE, 7'd0, 16'(OAM_FIRST + i),
                      (i % 4 == 0) ? 8'($urandom_range(8, 40))
                      : (i % 4 == 1) ? 8'($urandom_range(0, 168)) : 8'($urandom));
        for (int i = 0; i < 64; i++)
            send_item(OP_WRITE, 7'd0, 16'(16'h8000 + $urandom_range(0, 4095)), 8'($urandom));
        send_item(OP_WRITE, 7'd0, REG_LCDC, 8'h83);
        for (int i = 0; i < 60; i++) send_item(OP_TICK, 7'd64, 16'h0000, 8'h00);
    endtask

    initial
    begin
        errors = 0;
        sender_idle_on = 1'b1;
        receiver_idle_on = 1'b1;
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_TICK;
        ticks = 0;
        bus_address = 0;
        write_data = 0;
        model_reset();
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        test_registers();
        test_display_off();
        test_sprites();
        test_frames(900, 1'b1);
        sender_idle_on = 1'b0;
        receiver_idle_on = 1'b0;
        test_frames(400, 1'b0);
        drain_results();
        if (errors == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
